// ===== hw/rtl/hsfc_pkg.sv =====
// Shared types, constants and the CRC-8 byte update for the humidity sensor
// frame checker. No dependencies.
`timescale 1ns / 1ps

package hsfc_pkg;

  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [7:0]  CRC_INIT    = 8'hFF;
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [16:0] DIV_CONST   = 17'd65535;

  typedef struct packed {
    logic [15:0] raw_t;
    logic [15:0] raw_h;
    logic        t_bad;
    logic        h_bad;
  } hsfc_word_t;

  typedef struct packed {
    logic [15:0]        raw_t;
    logic [15:0]        raw_h;
    logic signed [14:0] temp_centi;
    logic [13:0]        hum_centi;
    logic               t_bad;
    logic               h_bad;
  } hsfc_result_t;

  // MSB-first CRC-8, no reflection, one byte unrolled
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] v;
    v = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

// ===== hw/rtl/hsfc_frame.sv =====
// Input beat register, byte position tracking and CRC check of one frame.
// Depends on hsfc_pkg.
`timescale 1ns / 1ps

module hsfc_frame import hsfc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_start,
  output logic       word_valid,
  input  logic       word_ready,
  output hsfc_word_t word
);

  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  logic       v0;
  logic [7:0] byte0;
  logic       start0;

  logic [2:0]  pos, pos_eff, pos_next;
  logic [7:0]  crc, crc_next;
  logic [15:0] tw, tw_next, hw, hw_next;
  logic        tfail, tfail_next;

  logic       v1;
  hsfc_word_t word_q;

  logic last, take1, consume;

  always_comb begin
    if (start0 || pos > POS_H_CRC) begin
      pos_eff = POS_T_MSB;
    end else begin
      pos_eff = pos;
    end
  end

  assign last     = (pos_eff == POS_H_CRC);
  assign take1    = !v1 || word_ready;
  assign consume  = v0 && (!last || take1);
  assign in_ready = !v0 || consume;

  always_comb begin
    pos_next   = pos;
    crc_next   = crc;
    tw_next    = tw;
    hw_next    = hw;
    tfail_next = tfail;
    unique case (pos_eff)
      POS_T_MSB: begin
        crc_next = crc8_feed(CRC_INIT, byte0);
        tw_next  = {byte0, tw[7:0]};
        pos_next = POS_T_LSB;
      end
      POS_T_LSB: begin
        crc_next = crc8_feed(crc, byte0);
        tw_next  = {tw[15:8], byte0};
        pos_next = POS_T_CRC;
      end
      POS_T_CRC: begin
        tfail_next = (crc != byte0);
        crc_next   = CRC_INIT;
        pos_next   = POS_H_MSB;
      end
      POS_H_MSB: begin
        crc_next = crc8_feed(CRC_INIT, byte0);
        hw_next  = {byte0, hw[7:0]};
        pos_next = POS_H_LSB;
      end
      POS_H_LSB: begin
        crc_next = crc8_feed(crc, byte0);
        hw_next  = {hw[15:8], byte0};
        pos_next = POS_H_CRC;
      end
      default: begin
        crc_next = CRC_INIT;
        pos_next = POS_T_MSB;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0    <= 1'b0;
      v1    <= 1'b0;
      pos   <= POS_T_MSB;
      crc   <= CRC_INIT;
      tw    <= '0;
      hw    <= '0;
      tfail <= 1'b0;
    end else begin
      if (in_ready) begin
        v0 <= in_valid;
      end
      if (take1) begin
        v1 <= consume && last;
      end
      if (consume) begin
        pos   <= pos_next;
        crc   <= crc_next;
        tw    <= tw_next;
        hw    <= hw_next;
        tfail <= tfail_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte0  <= in_byte;
      start0 <= in_start;
    end
    if (consume && last) begin
      word_q.raw_t <= tw;
      word_q.raw_h <= hw;
      word_q.t_bad <= tfail;
      word_q.h_bad <= (crc != byte0);
    end
  end

  assign word_valid = v1;
  assign word       = word_q;

endmodule

// ===== hw/rtl/hsfc_convert.sv =====
// Raw word scaling: product stage, divide by 65535, offset the temperature.
// Depends on hsfc_pkg.
`timescale 1ns / 1ps

module hsfc_convert import hsfc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         word_valid,
  output logic         word_ready,
  input  hsfc_word_t   word,
  output logic         res_valid,
  input  logic         res_ready,
  output hsfc_result_t res
);

  logic        v2;
  logic [30:0] prod_t;
  logic [29:0] prod_h;
  hsfc_word_t  word2;

  logic         v3;
  hsfc_result_t res_q;

  logic ready2, ready3;

  logic [14:0] q0_t, q_t;
  logic [16:0] r_t;
  logic [13:0] q0_h, q_h;
  logic [16:0] r_h;

  assign ready3     = !v3 || res_ready;
  assign ready2     = !v2 || ready3;
  assign word_ready = ready2;

  // x / 65535 = (x >> 16) plus one when the remainder reaches 65535
  always_comb begin
    q0_t = prod_t[30:16];
    r_t  = {1'b0, prod_t[15:0]} + {2'b00, q0_t};
    q_t  = q0_t + {14'd0, (r_t >= DIV_CONST)};
    q0_h = prod_h[29:16];
    r_h  = {1'b0, prod_h[15:0]} + {3'b000, q0_h};
    q_h  = q0_h + {13'd0, (r_h >= DIV_CONST)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready2) begin
        v2 <= word_valid;
      end
      if (ready3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (word_valid && ready2) begin
      prod_t <= {15'd0, word.raw_t} * {16'd0, TEMP_SCALE};
      prod_h <= {14'd0, word.raw_h} * {16'd0, HUM_SCALE};
      word2  <= word;
    end
    if (v2 && ready3) begin
      res_q.raw_t      <= word2.raw_t;
      res_q.raw_h      <= word2.raw_h;
      res_q.temp_centi <= $signed(q_t - TEMP_OFFSET);
      res_q.hum_centi  <= q_h;
      res_q.t_bad      <= word2.t_bad;
      res_q.h_bad      <= word2.h_bad;
    end
  end

  assign res_valid = v3;
  assign res       = res_q;

endmodule

// ===== hw/rtl/humidity_sensor_frame_checker.sv =====
// Top level of the humidity sensor frame checker: stream ports and packing.
// Depends on hsfc_pkg, hsfc_frame and hsfc_convert.
`timescale 1ns / 1ps

// Takes one frame byte per beat (temperature MSB, LSB, CRC, humidity MSB,
// LSB, CRC) and gives one result beat after every sixth byte. A byte with
// frame_start set is always taken as the first byte of a new frame; without
// it the position wraps after the sixth byte. CRC-8 (poly 0x31, init 0xFF) is
// checked per word and a mismatch is reported in the flags, but the result is
// still delivered. A byte can be accepted every cycle unless the output
// stalls; the CRC byte update is unrolled and the 16x15 and 16x14 scaling
// products are registered. A frame then passes the word, product and result
// registers, and output stalls hold the pipeline only as far back as needed.
module humidity_sensor_frame_checker import hsfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [15:0] raw_temperature, [31:16] raw_humidity,
                                      // [46:32] temperature_centi, [60:47] humidity_centi
  output logic [2:0]  m_axis_tuser    // [0] temperature_crc_bad, [1] humidity_crc_bad,
                                      // [2] status
);

  logic         word_valid, word_ready;
  hsfc_word_t   word;
  hsfc_result_t res;

  hsfc_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_start   (s_axis_tuser),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .word       (word)
  );

  hsfc_convert u_convert (
    .clk        (clk),
    .rst        (rst),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .word       (word),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res        (res)
  );

  assign m_axis_tdata = {3'b000, res.hum_centi, res.temp_centi, res.raw_h, res.raw_t};
  assign m_axis_tuser = {res.t_bad | res.h_bad, res.h_bad, res.t_bad};

endmodule

// ===== hw/rtl/hsfc_checker.sv =====
// Port-level checks for humidity_sensor_frame_checker and the bind that
// attaches them. Depends on the top level's port list only.
`timescale 1ns / 1ps

module hsfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser[2] == (m_axis_tuser[0] | m_axis_tuser[1]))
    else $error("status disagrees with CRC flags");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[46:32]) >= -15'sd4500)
      && ($signed(m_axis_tdata[46:32]) <= 15'sd13000))
    else $error("temperature out of range");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[60:47] <= 14'd10000) && (m_axis_tdata[63:61] == 3'b000))
    else $error("humidity out of range or pad bits set");

endmodule

bind humidity_sensor_frame_checker hsfc_checker u_hsfc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
